/* rtl/u8u16_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes of the UTF-8 to UTF-16LE converter.
package u8u16_pkg;

    // Input beat: one UTF-8 byte with its framing bits
    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       in_last;
    } in_beat_t;

    // Output beat: one UTF-16LE byte with its framing and final status
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } out_beat_t;

    // Final status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NUL      = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    // Work for the back end, produced by one input beat
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic [1:0]  n_units;  // code units to send: 0, 1 or 2
        logic        close;    // end of text: terminator or error byte follows
        logic [1:0]  status;   // final status, ST_OK when no error
    } cmd_t;

    // Configuration
    localparam int          CFG_WIDTH      = 31;
    localparam logic [30:0] MAX_TEXT_RESET = 31'd4096;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // UTF-8 byte classes and code point limits
    localparam logic [7:0]  ASCII_MAX      = 8'h7F;
    localparam logic [7:0]  LEAD2_LO       = 8'hC2;
    localparam logic [7:0]  LEAD2_HI       = 8'hDF;
    localparam logic [7:0]  LEAD3_LO       = 8'hE0;
    localparam logic [7:0]  LEAD3_HI       = 8'hEF;
    localparam logic [7:0]  LEAD4_LO       = 8'hF0;
    localparam logic [7:0]  LEAD4_HI       = 8'hF4;
    localparam logic [1:0]  CONT_TAG       = 2'b10;
    localparam logic [20:0] CP_MIN3        = 21'h000800;
    localparam logic [20:0] CP_PLANE1      = 21'h010000;
    localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [5:0]  HI_SURR_TAG    = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG    = 6'b110111;
    localparam logic [31:0] COUNT_SAT      = 32'hFFFF_FFFF;

endpackage

/* rtl/u8u16_front.sv */
`timescale 1ns / 1ps
// Front end: takes UTF-8 beats, validates and decodes them into commands.
module u8u16_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  u8u16_pkg::in_beat_t    s_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [u8u16_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output u8u16_pkg::cmd_t        q_cmd
);

    logic [u8u16_pkg::CFG_WIDTH-1:0] max_reg;
    logic [31:0] count_reg,  count_next;
    logic [1:0]  pend_reg,   pend_next;
    logic [1:0]  lead_reg,   lead_next;
    logic [20:0] acc_reg,    acc_next;
    logic        too_long_reg, too_long_next;
    logic        nul_reg,    nul_next;
    logic        invalid_reg, invalid_next;

    logic        accept;
    logic [7:0]  b;
    logic [20:0] acc_cat;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic        emit;
    logic        bad_cp;
    u8u16_pkg::cmd_t cmd;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign b         = s_data.in_byte;
    assign acc_cat   = {acc_reg[14:0], b[5:0]};
    assign cp_off    = cp - u8u16_pkg::CP_PLANE1;

    // Check a completed multi-byte sequence
    always_comb begin
        bad_cp = 1'b0;
        if (lead_reg == 2'd2 && acc_cat < u8u16_pkg::CP_MIN3) begin
            bad_cp = 1'b1;
        end
        if (lead_reg == 2'd3 && acc_cat < u8u16_pkg::CP_PLANE1) begin
            bad_cp = 1'b1;
        end
        if (acc_cat >= u8u16_pkg::CP_SURR_LO && acc_cat <= u8u16_pkg::CP_SURR_HI) begin
            bad_cp = 1'b1;
        end
        if (acc_cat > u8u16_pkg::CP_MAX) begin
            bad_cp = 1'b1;
        end
    end

    // Decode one beat: next text state and the command it yields
    always_comb begin
        count_next    = count_reg;
        pend_next     = pend_reg;
        lead_next     = lead_reg;
        acc_next      = acc_reg;
        too_long_next = too_long_reg;
        nul_next      = nul_reg;
        invalid_next  = invalid_reg;
        emit          = 1'b0;
        cp            = '0;
        cmd           = '0;
        cmd.status    = u8u16_pkg::ST_OK;

        if (s_data.has_byte) begin
            if (count_reg != u8u16_pkg::COUNT_SAT) begin
                count_next = count_reg + 32'd1;
            end
            if (count_next > {1'b0, max_reg}) begin
                too_long_next = 1'b1;
            end
            if (b == 8'h00) begin
                nul_next = 1'b1;
            end
            if (!invalid_reg) begin
                if (pend_reg == 2'd0) begin
                    if (b <= u8u16_pkg::ASCII_MAX) begin
                        emit = 1'b1;
                        cp   = {13'd0, b};
                    end else if (b inside {[u8u16_pkg::LEAD2_LO:u8u16_pkg::LEAD2_HI]}) begin
                        pend_next = 2'd1;
                        lead_next = 2'd1;
                        acc_next  = {16'd0, b[4:0]};
                    end else if (b inside {[u8u16_pkg::LEAD3_LO:u8u16_pkg::LEAD3_HI]}) begin
                        pend_next = 2'd2;
                        lead_next = 2'd2;
                        acc_next  = {17'd0, b[3:0]};
                    end else if (b inside {[u8u16_pkg::LEAD4_LO:u8u16_pkg::LEAD4_HI]}) begin
                        pend_next = 2'd3;
                        lead_next = 2'd3;
                        acc_next  = {18'd0, b[2:0]};
                    end else begin
                        invalid_next = 1'b1;
                    end
                end else if (b[7:6] != u8u16_pkg::CONT_TAG) begin
                    invalid_next = 1'b1;
                    pend_next    = 2'd0;
                end else begin
                    acc_next  = acc_cat;
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1) begin
                        if (bad_cp) begin
                            invalid_next = 1'b1;
                        end else begin
                            emit = 1'b1;
                            cp   = acc_cat;
                        end
                    end
                end
            end
        end

        // Split the code point into UTF-16 units unless an error is pending
        if (emit && !too_long_next && !nul_next) begin
            if (cp >= u8u16_pkg::CP_PLANE1) begin
                cmd.unit0   = {u8u16_pkg::HI_SURR_TAG, cp_off[19:10]};
                cmd.unit1   = {u8u16_pkg::LO_SURR_TAG, cp_off[9:0]};
                cmd.n_units = 2'd2;
            end else begin
                cmd.unit0   = cp[15:0];
                cmd.n_units = 2'd1;
            end
        end

        // Close the text: final status, then clear the text state
        if (s_data.in_last) begin
            if (pend_next != 2'd0) begin
                invalid_next = 1'b1;
            end
            cmd.close = 1'b1;
            if (too_long_next) begin
                cmd.status = u8u16_pkg::ST_TOO_LONG;
            end else if (nul_next) begin
                cmd.status = u8u16_pkg::ST_NUL;
            end else if (invalid_next) begin
                cmd.status = u8u16_pkg::ST_INVALID;
            end
            count_next    = '0;
            pend_next     = '0;
            lead_next     = '0;
            acc_next      = '0;
            too_long_next = 1'b0;
            nul_next      = 1'b0;
            invalid_next  = 1'b0;
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.n_units != 2'd0 || cmd.close);

    // Hold the length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= u8u16_pkg::MAX_TEXT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_reg <= cfg_data;
        end
    end

    // Advance the text state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pend_reg     <= '0;
            lead_reg     <= '0;
            acc_reg      <= '0;
            too_long_reg <= 1'b0;
            nul_reg      <= 1'b0;
            invalid_reg  <= 1'b0;
        end else if (accept) begin
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            lead_reg     <= lead_next;
            acc_reg      <= acc_next;
            too_long_reg <= too_long_next;
            nul_reg      <= nul_next;
            invalid_reg  <= invalid_next;
        end
    end

    // A closed text leaves the counter and flags clear
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.in_last) |=>
            (count_reg == '0 && pend_reg == 2'd0 && !invalid_reg && !nul_reg))
        else $error("text state not cleared after end of text");

    // Once invalid, no further sequence is pending
    a_invalid_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        invalid_reg |-> (pend_reg == 2'd0 || $past(invalid_reg) == 1'b0))
        else $error("sequence pending while text is invalid");

endmodule

/* rtl/u8u16_fifo.sv */
`timescale 1ns / 1ps
// Command queue between the front and back ends.
module u8u16_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u8u16_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output u8u16_pkg::cmd_t   head
);

    u8u16_pkg::cmd_t                  mem_reg [u8u16_pkg::QUEUE_DEPTH];
    logic [u8u16_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [u8u16_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [u8u16_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == u8u16_pkg::QCNT_W'(u8u16_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    // Occupancy stays within depth and tracks the pointers
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= u8u16_pkg::QCNT_W'(u8u16_pkg::QUEUE_DEPTH)) &&
        (u8u16_pkg::QPTR_W'(cnt_reg) == u8u16_pkg::QPTR_W'(wr_reg - rd_reg)))
        else $error("queue occupancy out of step with pointers");

endmodule

/* rtl/u8u16_back.sv */
`timescale 1ns / 1ps
// Back end: serializes commands into UTF-16LE output beats.
module u8u16_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  u8u16_pkg::cmd_t        q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output u8u16_pkg::out_beat_t   m_data
);

    logic [2:0]           idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    u8u16_pkg::out_beat_t m_data_reg, m_data_next;

    logic [2:0]  data_len;
    logic [2:0]  total_len;
    logic        final_byte;
    logic        load;
    logic [15:0] unit;

    // Bytes in the current command: unit bytes, then one error byte or two terminator bytes
    always_comb begin
        data_len  = {q_head.n_units, 1'b0};
        total_len = data_len;
        if (q_head.close) begin
            total_len = (q_head.status == u8u16_pkg::ST_OK) ? data_len + 3'd2
                                                            : data_len + 3'd1;
        end
    end

    assign final_byte = (idx_reg == total_len - 3'd1);
    assign load       = !m_valid_reg || m_ready;
    assign q_pop      = load && !q_empty && final_byte;
    assign unit       = idx_reg[1] ? q_head.unit1 : q_head.unit0;

    // Pick the next byte and advance through the command
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = !q_empty;
            if (!q_empty) begin
                if (idx_reg < data_len) begin
                    m_data_next.out_byte = idx_reg[0] ? unit[15:8] : unit[7:0];
                    m_data_next.out_last = 1'b0;
                    m_data_next.status   = u8u16_pkg::ST_OK;
                end else begin
                    m_data_next.out_byte = 8'h00;
                    m_data_next.out_last = final_byte;
                    m_data_next.status   = final_byte ? q_head.status : u8u16_pkg::ST_OK;
                end
                idx_next = final_byte ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A nonzero status only rides on the last beat of a text
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != u8u16_pkg::ST_OK) |-> m_data.out_last)
        else $error("error status on a non-final beat");

    // The byte index stays inside the command being sent
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (idx_reg < total_len))
        else $error("byte index past end of command");

endmodule

/* rtl/utf8_to_utf16le_converter_top.sv */
`timescale 1ns / 1ps
// Top level of the strict UTF-8 to UTF-16LE converter.
// Path: an accepted input beat is written into the command queue, and its first output byte is then
//   loaded into the output register. Output: the back end sends one output byte per cycle while m_ready
//   is high; an input beat yields 2 bytes for ASCII, up to 6; the four-entry command queue absorbs bursts.
// Input beats that yield no output (lead and middle bytes) are taken at one per cycle
//   while the queue is not full.
// Reset: synchronous, active low; clears text state, queue and output valid flag, and the
//   text length limit returns to 4096.
module utf8_to_utf16le_converter_top (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  u8u16_pkg::in_beat_t    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output u8u16_pkg::out_beat_t   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [u8u16_pkg::CFG_WIDTH-1:0] cfg_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    u8u16_pkg::cmd_t q_cmd;
    u8u16_pkg::cmd_t q_head;

    // Validate and decode
    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Decouple the two ends
    u8u16_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Serialize to bytes
    u8u16_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the UTF-8 to UTF-16LE converter, with its own transcoding predictor.
module testbench;

    localparam int SETTLE_CYCLES = 8;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    u8u16_pkg::in_beat_t             s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    u8u16_pkg::out_beat_t            m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [u8u16_pkg::CFG_WIDTH-1:0] cfg_data  = '0;

    utf8_to_utf16le_converter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predictor state: register copy and per-text decode state
    logic [u8u16_pkg::CFG_WIDTH-1:0] max_len;
    logic [31:0]          text_len;
    logic [1:0]           cont_left;
    logic [1:0]           seq_len;
    logic [20:0]          cp_acc;
    logic                 too_long;
    logic                 saw_nul;
    logic                 bad_utf8;

    u8u16_pkg::out_beat_t utf16_due[$];
    logic [7:0]           text_buf[$];
    u8u16_pkg::out_beat_t want;
    int         mismatch_cnt = 0;
    int         beats_sent   = 0;
    int         stall_left   = 0;
    bit         tx_gaps      = 1'b0;
    bit         rx_stalls    = 1'b0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void restart_text();
        text_len  = '0;
        cont_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
        too_long  = 1'b0;
        saw_nul   = 1'b0;
        bad_utf8  = 1'b0;
    endfunction

    function automatic void push_beat(logic [7:0] b, logic last, logic [1:0] st);
        u8u16_pkg::out_beat_t o;
        o.out_byte = b;
        o.out_last = last;
        o.status   = st;
        utf16_due.push_back(o);
    endfunction

    function automatic void push_unit(logic [15:0] u);
        push_beat(u[7:0], 1'b0, u8u16_pkg::ST_OK);
        push_beat(u[15:8], 1'b0, u8u16_pkg::ST_OK);
    endfunction

    // Emit one code point as UTF-16LE unless the text already failed
    function automatic void push_code_point(logic [20:0] cp);
        logic [20:0] v;
        if (too_long || saw_nul || bad_utf8)
            return;
        if (cp >= u8u16_pkg::CP_PLANE1) begin
            v = cp - u8u16_pkg::CP_PLANE1;
            push_unit({u8u16_pkg::HI_SURR_TAG, v[19:10]});
            push_unit({u8u16_pkg::LO_SURR_TAG, v[9:0]});
        end else begin
            push_unit(cp[15:0]);
        end
    endfunction

    // Count, check and decode one real text byte
    function automatic void take_text_byte(logic [7:0] b);
        logic [20:0] cp;
        if (text_len != u8u16_pkg::COUNT_SAT)
            text_len = text_len + 32'd1;
        if (text_len > {1'b0, max_len})
            too_long = 1'b1;
        if (b == 8'h00)
            saw_nul = 1'b1;
        if (bad_utf8)
            return;

        if (cont_left == 2'd0) begin
            if (b <= u8u16_pkg::ASCII_MAX) begin
                push_code_point({13'd0, b});
                return;
            end
            if (b >= u8u16_pkg::LEAD2_LO && b <= u8u16_pkg::LEAD2_HI) begin
                cont_left = 2'd1;
                cp_acc    = {16'd0, b[4:0]};
            end else if (b >= u8u16_pkg::LEAD3_LO && b <= u8u16_pkg::LEAD3_HI) begin
                cont_left = 2'd2;
                cp_acc    = {17'd0, b[3:0]};
            end else if (b >= u8u16_pkg::LEAD4_LO && b <= u8u16_pkg::LEAD4_HI) begin
                cont_left = 2'd3;
                cp_acc    = {18'd0, b[2:0]};
            end else begin
                bad_utf8 = 1'b1;
                return;
            end
            seq_len = cont_left;
            return;
        end

        if (b[7:6] != u8u16_pkg::CONT_TAG) begin
            bad_utf8  = 1'b1;
            cont_left = 2'd0;
            return;
        end
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0)
            return;
        cp = cp_acc;
        // Reject overlong three- and four-byte forms, surrogates and values past the top
        if ((seq_len == 2'd2 && cp < u8u16_pkg::CP_MIN3) ||
            (seq_len == 2'd3 && cp < u8u16_pkg::CP_PLANE1) ||
            (cp >= u8u16_pkg::CP_SURR_LO && cp <= u8u16_pkg::CP_SURR_HI) ||
            cp > u8u16_pkg::CP_MAX) begin
            bad_utf8 = 1'b1;
            return;
        end
        push_code_point(cp);
    endfunction

    // Work out the output beats that one accepted input beat causes
    function automatic void transcode_beat(u8u16_pkg::in_beat_t beat);
        logic [1:0] st;
        if (beat.has_byte)
            take_text_byte(beat.in_byte);
        if (!beat.in_last)
            return;
        if (cont_left != 2'd0)
            bad_utf8 = 1'b1;
        if (too_long || saw_nul || bad_utf8) begin
            st = too_long ? u8u16_pkg::ST_TOO_LONG
                          : (saw_nul ? u8u16_pkg::ST_NUL : u8u16_pkg::ST_INVALID);
            push_beat(8'h00, 1'b1, st);
        end else begin
            push_beat(8'h00, 1'b0, u8u16_pkg::ST_OK);
            push_beat(8'h00, 1'b1, u8u16_pkg::ST_OK);
        end
        restart_text();
    endfunction

    // Append the UTF-8 form of a value; also builds surrogates and values past the top
    function automatic void append_code_point(logic [20:0] cp);
        if (cp <= {13'd0, u8u16_pkg::ASCII_MAX}) begin
            text_buf.push_back(cp[7:0]);
        end else if (cp < u8u16_pkg::CP_MIN3) begin
            text_buf.push_back({3'b110, cp[10:6]});
            text_buf.push_back({u8u16_pkg::CONT_TAG, cp[5:0]});
        end else if (cp < u8u16_pkg::CP_PLANE1) begin
            text_buf.push_back({4'b1110, cp[15:12]});
            text_buf.push_back({u8u16_pkg::CONT_TAG, cp[11:6]});
            text_buf.push_back({u8u16_pkg::CONT_TAG, cp[5:0]});
        end else begin
            text_buf.push_back({5'b11110, cp[20:18]});
            text_buf.push_back({u8u16_pkg::CONT_TAG, cp[17:12]});
            text_buf.push_back({u8u16_pkg::CONT_TAG, cp[11:6]});
            text_buf.push_back({u8u16_pkg::CONT_TAG, cp[5:0]});
        end
    endfunction

    // Any legal non-NUL scalar value, ASCII weighted up
    function automatic logic [20:0] random_code_point();
        logic [20:0] cp;
        case ($urandom_range(0, 5))
            0, 1, 2: cp = 21'($urandom_range(1, 'h7F));
            3:       cp = 21'($urandom_range('h80, 'h7FF));
            4: begin
                do cp = 21'($urandom_range('h800, 'hFFFF));
                while (cp >= u8u16_pkg::CP_SURR_LO && cp <= u8u16_pkg::CP_SURR_HI);
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // One broken sequence of a random kind
    function automatic void append_broken_sequence();
        case ($urandom_range(0, 5))
            0: append_code_point(21'($urandom_range(u8u16_pkg::CP_SURR_LO,
                                                    u8u16_pkg::CP_SURR_HI)));
            1: append_code_point(21'($urandom_range('h110000, 'h1FFFFF)));
            2: begin
                text_buf.push_back(u8u16_pkg::LEAD3_LO);
                text_buf.push_back(8'($urandom_range('h80, 'h9F)));
                text_buf.push_back({u8u16_pkg::CONT_TAG, 6'($urandom)});
            end
            3: begin
                text_buf.push_back(u8u16_pkg::LEAD4_LO);
                text_buf.push_back(8'($urandom_range('h80, 'h8F)));
                text_buf.push_back({u8u16_pkg::CONT_TAG, 6'($urandom)});
                text_buf.push_back({u8u16_pkg::CONT_TAG, 6'($urandom)});
            end
            4: begin
                // truncate a multi-byte form
                append_code_point(21'($urandom_range('h80, 'h10FFFF)));
                void'(text_buf.pop_back());
            end
            default: begin
                // two-byte overlong lead or a stray continuation
                if ($urandom_range(0, 1))
                    text_buf.push_back(8'($urandom_range('hC0, 'hC1)));
                text_buf.push_back({u8u16_pkg::CONT_TAG, 6'($urandom)});
            end
        endcase
    endfunction

    // Fill the text buffer: mostly well-formed, some noise, some broken
    function automatic void build_random_text();
        int n;
        int k;
        text_buf.delete();
        k = $urandom_range(0, 9);
        n = $urandom_range(0, 6);
        if (k <= 6) begin
            repeat (n) append_code_point(random_code_point());
        end else if (k == 7) begin
            repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 2)) append_code_point(random_code_point());
            append_broken_sequence();
            repeat ($urandom_range(0, 2)) append_code_point(random_code_point());
        end
    endfunction

    // Send one input beat, predict on acceptance, then idle for a random gap when gaps are enabled
    task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
        u8u16_pkg::in_beat_t beat;
        int                  gap;
        beat.in_byte  = b;
        beat.has_byte = has;
        beat.in_last  = last;
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk);
        while (!s_ready);
        transcode_beat(beat);
        beats_sent++;
        gap = tx_gaps ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and hold until every predicted beat has come out
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (utf16_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_text_limit(input logic [u8u16_pkg::CFG_WIDTH-1:0] v);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len = v;
    endtask

    // Send the buffered text; close it on its last byte or with a no-byte end beat
    task automatic send_text(input bit end_marker, input bit hold_off);
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            if ($urandom_range(0, 11) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            if (hold_off && i > 0 && i == text_buf.size() / 2)
                hold_until_drained();
            send_beat(text_buf[i], 1'b1, !end_marker && i == text_buf.size() - 1);
        end
        if (end_marker || text_buf.size() == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Output side: random stalls, when enabled
    always @(posedge aclk) begin
        if (!rx_stalls) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                stall_left = idle_length();
        end
    end

    task automatic report_mismatch(input u8u16_pkg::out_beat_t w,
                                   input u8u16_pkg::out_beat_t got, input bit orphan);
        if (mismatch_cnt < 10) begin
            if (orphan)
                $display("%0t: unexpected output beat: byte %02h last %0b status %0d",
                         $realtime, got.out_byte, got.out_last, got.status);
            else
                $display("%0t: got byte/last/status %02h/%0b/%0d, want %02h/%0b/%0d",
                         $realtime, got.out_byte, got.out_last, got.status,
                         w.out_byte, w.out_last, w.status);
        end
        mismatch_cnt++;
    endtask

    // Compare every output beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (utf16_due.size() == 0) begin
                report_mismatch(m_data, m_data, 1'b1);
            end else begin
                want = utf16_due.pop_front();
                if (m_data.out_byte !== want.out_byte || m_data.out_last !== want.out_last ||
                    m_data.status !== want.status)
                    report_mismatch(want, m_data, 1'b0);
            end
        end
    end

    // Extremes of each sequence length, ignored beat, empty text, end beat after bytes
    task automatic test_valid_forms();
        text_buf.delete();
        append_code_point(21'h00007F);
        append_code_point(21'h000080);
        append_code_point(21'h00FFFF);
        append_code_point(21'h10FFFF);
        send_text(1'b0, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
        text_buf.delete();
        text_buf.push_back(8'h41);
        send_text(1'b1, 1'b0);
    endtask

    // Each fault once; NUL after an invalid byte must win
    task automatic test_fault_status();
        text_buf = '{8'h80, 8'h00};
        send_text(1'b0, 1'b0);
        text_buf = '{u8u16_pkg::LEAD3_LO, 8'h9F, 8'hBF};
        send_text(1'b0, 1'b0);
        text_buf.delete();
        append_code_point(u8u16_pkg::CP_SURR_LO);
        send_text(1'b0, 1'b0);
        text_buf.delete();
        append_code_point(u8u16_pkg::CP_MAX + 21'd1);
        send_text(1'b0, 1'b0);
        text_buf = '{u8u16_pkg::LEAD2_LO};
        send_text(1'b0, 1'b0);
    endtask

    // Byte limit at zero and at a small value; too long beats NUL and invalid
    task automatic test_byte_limit();
        set_text_limit('0);
        send_beat(8'h41, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        set_text_limit(31'd3);
        text_buf = '{8'h41, 8'h42, 8'h43};
        send_text(1'b0, 1'b0);
        text_buf = '{8'hFF, 8'h41, 8'h00, 8'h42};
        send_text(1'b0, 1'b0);
    endtask

    task automatic test_random_texts(input logic [u8u16_pkg::CFG_WIDTH-1:0] limit,
                                     input bit gaps, input bit stalls, input bit hold_off,
                                     input int n_beats);
        int goal;
        set_text_limit(limit);
        tx_gaps   = gaps;
        rx_stalls = stalls;
        goal      = beats_sent + n_beats;
        while (beats_sent < goal) begin
            build_random_text();
            send_text($urandom_range(0, 7) == 0, hold_off);
        end
    endtask

    initial begin
        max_len = u8u16_pkg::MAX_TEXT_RESET;
        restart_text();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        test_valid_forms();
        test_fault_status();
        test_byte_limit();

        test_random_texts(u8u16_pkg::MAX_TEXT_RESET, 1'b0, 1'b0, 1'b0, 17);
        test_random_texts(31'($urandom_range(4, 24)), 1'b1, 1'b1, 1'b0, 17);
        test_random_texts(31'h7FFF_FFFE, 1'b1, 1'b1, 1'b1, 17);
        test_random_texts(31'($urandom_range(0, 32'h7FFF_FFFE)), 1'b0, 1'b1, 1'b0, 17);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
